// ===== hdl/grlm_pkg.sv =====
// Shared constants, types and controller codes for the gated RMS level meter.
package grlm_pkg;

  localparam int BLOCK_SAMPLES = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int FILL_W        = 11;
  localparam int SUM_W         = 41;
  localparam int POW_W         = 204;
  localparam int LEVEL_W       = 7;
  localparam int DEPTH_W       = 7;
  localparam int LEVEL_FLOOR   = 64;
  localparam int BIT_CNT_W     = 6;
  localparam int THR_W         = 15;
  localparam int CFG_IDX_W     = 2;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ENABLE  = 2'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_START,
    OP_END,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PINIT,
    ST_MLOAD,
    ST_MSTEP,
    ST_MSTORE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sel_num;
    logic pow_init;
    logic mul_load;
    logic mul_step;
    logic mul_store;
    logic den_save;
    logic num_save;
    logic srch_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic rep_go;
    logic srch_stop;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== hdl/grlm_in_if.sv =====
// Input channel: command and audio sample.
interface grlm_in_if;
  import grlm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, cmd, sample_in, input ready);
  modport sink (input valid, cmd, sample_in, output ready);
endinterface

// ===== hdl/grlm_out_if.sv =====
// Result channel: gained sample and level report.
interface grlm_out_if;
  import grlm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          report_valid;
  logic signed [LEVEL_W-1:0]     level_db;
  logic signed [LEVEL_W-1:0]     average_db;
  modport source (output valid, sample_out, report_valid, level_db, average_db, input ready);
  modport sink (input valid, sample_out, report_valid, level_db, average_db, output ready);
endinterface

// ===== hdl/grlm_cfg_if.sv =====
// Configuration write channel.
interface grlm_cfg_if;
  import grlm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/grlm_ctrl.sv =====
// Controller state machine sequencing sample updates, power products and the level search.
module grlm_ctrl import grlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0]           mul_cnt_r, mul_cnt_nxt;
  logic                 phase_num_r, phase_num_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      mul_cnt_r   <= '0;
      phase_num_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      phase_num_r <= phase_num_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    mul_cnt_nxt   = mul_cnt_r;
    phase_num_nxt = phase_num_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.rep_go) begin
          phase_num_nxt = 1'b0;
          state_nxt     = ST_PINIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PINIT: begin
        mul_cnt_nxt = '0;
        state_nxt   = ST_MLOAD;
      end
      ST_MLOAD: begin
        bit_cnt_nxt = '0;
        state_nxt   = ST_MSTEP;
      end
      ST_MSTEP: begin
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(SUM_W - 1)) state_nxt = ST_MSTORE;
      end
      ST_MSTORE: begin
        if (mul_cnt_r == 2'd3) begin
          if (!phase_num_r) begin
            phase_num_nxt = 1'b1;
            state_nxt     = ST_PINIT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end else begin
          mul_cnt_nxt = mul_cnt_r + 1'b1;
          state_nxt   = ST_MLOAD;
        end
      end
      ST_SEARCH: begin
        if (sts.srch_stop) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.sel_num = phase_num_r;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC:   cmd.exec = 1'b1;
      ST_PINIT:  cmd.pow_init = 1'b1;
      ST_MLOAD:  cmd.mul_load = 1'b1;
      ST_MSTEP:  cmd.mul_step = 1'b1;
      ST_MSTORE: begin
        cmd.mul_store = 1'b1;
        cmd.den_save  = (mul_cnt_r == 2'd3) && !phase_num_r;
        cmd.num_save  = (mul_cnt_r == 2'd3) && phase_num_r;
      end
      ST_SEARCH: cmd.srch_step = !sts.srch_stop;
      ST_FINISH: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/grlm_dp.sv =====
// Datapath: gain, gated accumulation, fifth-power products, decade search and result register.
module grlm_dp import grlm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctl_cmd_t                      cmd,
  output ctl_sts_t                      sts,
  input  logic [1:0]                    in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [THR_W-1:0]              cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_report,
  output logic signed [LEVEL_W-1:0]     out_level,
  output logic signed [LEVEL_W-1:0]     out_average
);

  localparam int PROD_W = SAMPLE_BITS + 4;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(1 << (SAMPLE_BITS - 1));
  localparam int SHIFT = 2 * (SAMPLE_BITS - 1);

  logic [THR_W-1:0]              thr_r;
  logic                          en_r;
  op_t                           op_r;
  logic signed [SAMPLE_BITS-1:0] gained_r;
  logic [SUM_W-1:0]              sum_r;
  logic [FILL_W-1:0]             fill_r, gated_r;
  logic signed [LEVEL_W-1:0]     avg_r;
  logic                          avg_vld_r;
  logic                          rep_pend_r;
  logic [SUM_W-1:0]              rep_sum_r;
  logic [FILL_W-1:0]             rep_cnt_r;
  logic [POW_W-1:0]              pow_r, acc_r, mcand_r, den_r, num_r;
  logic [SUM_W-1:0]              mplier_r;
  logic [DEPTH_W-1:0]            k_r;
  logic                          out_valid_r, out_report_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic signed [LEVEL_W-1:0]     out_level_r, out_average_r;

  // Gain of fifteen with saturation, formed at the transfer.
  logic signed [PROD_W-1:0]      ext, prod;
  logic signed [SAMPLE_BITS-1:0] sat;
  op_t                           op_in;

  always_comb begin
    ext  = PROD_W'(in_sample);
    prod = (ext <<< 4) - ext;
    if (prod > SAT_HI)      sat = SAMPLE_BITS'(SAT_HI);
    else if (prod < SAT_LO) sat = SAMPLE_BITS'(SAT_LO);
    else                    sat = SAMPLE_BITS'(prod);
    if (!en_r)                      op_in = OP_NONE;
    else if (in_cmd == CMD_SAMPLE)  op_in = OP_SAMPLE;
    else if (in_cmd == CMD_START)   op_in = OP_START;
    else if (in_cmd == CMD_END)     op_in = OP_END;
    else                            op_in = OP_NONE;
  end

  // Gated accumulation of the latched sample.
  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic                   qual;
  logic [SUM_W-1:0]       sum_new;
  logic [FILL_W-1:0]      fill_new, gated_new;
  logic                   full;

  always_comb begin
    mag       = gained_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-gained_r) : SAMPLE_BITS'(gained_r);
    qual      = mag > {1'b0, thr_r};
    sq        = mag * mag;
    sum_new   = qual ? sum_r + SUM_W'(sq) : sum_r;
    gated_new = qual ? gated_r + 1'b1 : gated_r;
    fill_new  = fill_r + 1'b1;
    full      = fill_new == FILL_W'(BLOCK_SAMPLES);
  end

  always_comb begin
    sts.rep_go = 1'b0;
    unique case (op_r)
      OP_SAMPLE: sts.rep_go = full && (gated_new != '0);
      OP_END:    sts.rep_go = (fill_r != '0) && (gated_r != '0);
      OP_START, OP_NONE: sts.rep_go = 1'b0;
      default:   sts.rep_go = 1'b0;
    endcase
  end

  // Shift-add multiplier shared by both fifth powers.
  logic [SUM_W-1:0] base;
  assign base = cmd.sel_num ? rep_sum_r : {rep_cnt_r, SHIFT'(0)};

  // One decade step of the search.
  logic [POW_W-1:0] next_num;
  assign next_num = (num_r << 3) + (num_r << 1);
  assign sts.srch_stop = (k_r == DEPTH_W'(LEVEL_FLOOR)) || (next_num > den_r);

  // Running average; levels are never positive, so adding one before the
  // arithmetic shift truncates toward zero.
  logic signed [LEVEL_W-1:0] lvl;
  logic signed [LEVEL_W:0]   avg_sum;
  logic signed [LEVEL_W-1:0] avg_nxt;
  logic                      avg_vld_nxt;

  always_comb begin
    lvl         = -LEVEL_W'(k_r);
    avg_sum     = (LEVEL_W+1)'(avg_r) + (LEVEL_W+1)'(lvl) + (LEVEL_W+1)'(1);
    avg_nxt     = avg_r;
    avg_vld_nxt = avg_vld_r;
    if (rep_pend_r) begin
      avg_vld_nxt = 1'b1;
      avg_nxt     = avg_vld_r ? LEVEL_W'(avg_sum >>> 1) : lvl;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      en_r        <= 1'b1;
      op_r        <= OP_NONE;
      sum_r       <= '0;
      fill_r      <= '0;
      gated_r     <= '0;
      avg_r       <= '0;
      avg_vld_r   <= 1'b0;
      rep_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GATE_THRESHOLD) thr_r <= cfg_data;
        if (cfg_index == REG_STREAM_ENABLE)  en_r  <= cfg_data[0];
      end
      if (cmd.accept) begin
        op_r       <= op_in;
        gained_r   <= (op_in == OP_SAMPLE) ? sat : '0;
        rep_pend_r <= 1'b0;
      end
      if (cmd.exec) begin
        rep_pend_r <= sts.rep_go;
        unique case (op_r)
          OP_SAMPLE: begin
            rep_sum_r <= sum_new;
            rep_cnt_r <= gated_new;
            if (full) begin
              sum_r   <= '0;
              fill_r  <= '0;
              gated_r <= '0;
            end else begin
              sum_r   <= sum_new;
              fill_r  <= fill_new;
              gated_r <= gated_new;
            end
          end
          OP_START: begin
            sum_r     <= '0;
            fill_r    <= '0;
            gated_r   <= '0;
            avg_r     <= '0;
            avg_vld_r <= 1'b0;
          end
          OP_END: begin
            rep_sum_r <= sum_r;
            rep_cnt_r <= gated_r;
            if (fill_r != '0) begin
              sum_r   <= '0;
              fill_r  <= '0;
              gated_r <= '0;
            end
          end
          OP_NONE: ;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        avg_r         <= avg_nxt;
        avg_vld_r     <= avg_vld_nxt;
        out_sample_r  <= gained_r;
        out_report_r  <= rep_pend_r;
        out_level_r   <= rep_pend_r ? lvl : '0;
        out_average_r <= avg_vld_nxt ? avg_nxt : '0;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Wide arithmetic registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.pow_init) pow_r <= POW_W'(base);
    if (cmd.mul_load) begin
      acc_r    <= '0;
      mcand_r  <= pow_r;
      mplier_r <= base;
    end
    if (cmd.mul_step) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.mul_store) pow_r <= acc_r;
    if (cmd.den_save)  den_r <= acc_r;
    if (cmd.num_save) begin
      num_r <= acc_r;
      k_r   <= '0;
    end
    if (cmd.srch_step) begin
      num_r <= next_num;
      k_r   <= k_r + 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_report  = out_report_r;
  assign out_level   = out_level_r;
  assign out_average = out_average_r;

endmodule

// ===== hdl/gained_gated_rms_level_meter.sv =====
// Gated RMS level meter: an item that closes a block with a report computes two fifth
// powers on one 41-step shift-add multiplier, then takes up to 64 decade steps of the level
// search. One item is in work at a time; the result register lets the next item be taken
// while a result waits. Synchronous active-low reset clears the accumulators, the running
// average, gate_threshold to 0 and stream_enable to 1.
module gained_gated_rms_level_meter import grlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  grlm_in_if.sink   in_ch,
  grlm_out_if.source out_ch,
  grlm_cfg_if.sink  cfg_ch
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  grlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grlm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_cmd      (in_ch.cmd),
    .in_sample   (in_ch.sample_in),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_sample  (out_ch.sample_out),
    .out_report  (out_ch.report_valid),
    .out_level   (out_ch.level_db),
    .out_average (out_ch.average_db)
  );

endmodule
